// ===== rtl/dic_pkg.sv =====
package dic_pkg;

  // default store size, values 1 to MAX_ELEMS
  localparam int MAX_ELEMS_DEF = 1024;

  localparam int VAL_W = 11;
  localparam int CNT_W = 19;

  // op codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] inversions_before;
    logic [CNT_W-1:0] inversions_after;
    logic [1:0]       status;
  } out_word_t;

  // sequencer to compare unit
  typedef struct packed {
    logic clear;
    logic valid;
    logic is_del;
  } cmp_ctrl_t;

endpackage

// ===== rtl/dynamic_inversion_counter.sv =====
// Dynamic inversion counter. Keeps a sequence of distinct values 1..MAX_ELEMS
// and its inversion count. Each input word carries op (append, delete, clear)
// and a value; each gives exactly one result word with the count before and
// after and a status (ok, out of range, duplicate or absent, full). Rejected
// words leave the count unchanged. A deleted slot is only reused after a
// clear. An append or delete runs a lookup, then one comparator walks every
// used slot of the slot memory once (one read a cycle), then pipeline drain,
// write and finish steps; an out-of-range word goes straight to the finish
// step, a duplicate, absent or full word goes there after the lookup, and a
// clear is followed by a clearing pass over the value-to-slot memory. The
// same clearing pass runs after reset; in_stall is high during it. One word
// is worked on at a time; the result sits in an output register so the next
// word can be taken while it waits. A result word still held by out_stall
// keeps the finish step waiting.
module dynamic_inversion_counter #(
  parameter int MAX_ELEMS = dic_pkg::MAX_ELEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dic_pkg::in_word_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output dic_pkg::out_word_t out_word
);
  import dic_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);     // slot / value index
  localparam int LW = $clog2(MAX_ELEMS + 1); // sequence length
  localparam int TW = 2 * LW;                // inversion total
  localparam int CW = VAL_W + 2;             // range compare
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ELEMS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [AW-1:0] k_r, k_nxt;           // value minus one
  logic [AW-1:0] pos_r, pos_nxt;       // slot of the word being deleted
  logic [1:0]    status_r, status_nxt;
  logic [TW-1:0] before_r, before_nxt;
  logic [LW-1:0] seq_len_r, seq_len_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [LW-1:0] scan_p_r, scan_p_nxt; // next slot to read
  logic          pv_r, pv_nxt;         // read data in flight
  logic [AW-1:0] pp_r, pp_nxt;         // slot of the read data
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic          clr_pend_r, clr_pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;

  // slot memory: {alive, value minus one} per position
  logic          slot_we, slot_re;
  logic [AW-1:0] slot_waddr, slot_raddr;
  logic [AW:0]   slot_wdata, slot_rdata;

  // value memory: {loaded, position} per value
  logic          pv_we, pv_re;
  logic [AW-1:0] pv_waddr, pv_raddr;
  logic [AW:0]   pv_wdata, pv_rdata;

  cmp_ctrl_t     cmp_ctrl;
  logic [LW-1:0] cnt;

  logic          in_range;
  logic [AW-1:0] in_k;

  assign in_range = (in_word.value != '0) &&
                    (CW'(in_word.value) <= CW'(MAX_ELEMS));
  assign in_k     = AW'(in_word.value - VAL_W'(1));

  dic_ram #(.WIDTH(AW + 1), .DEPTH(MAX_ELEMS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  dic_ram #(.WIDTH(AW + 1), .DEPTH(MAX_ELEMS)) u_val_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .re    (pv_re),
    .raddr (pv_raddr),
    .rdata (pv_rdata)
  );

  assign cmp_ctrl.clear  = (state_r == S_LOOK);
  assign cmp_ctrl.valid  = pv_r;
  assign cmp_ctrl.is_del = (op_r == OP_DELETE);

  dic_cmp_unit #(.AW(AW), .LW(LW)) u_cmp (
    .clk       (clk),
    .ctrl      (cmp_ctrl),
    .slot_word (slot_rdata),
    .p         (pp_r),
    .pos       (pos_r),
    .k         (k_r),
    .cnt       (cnt)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    status_nxt    = status_r;
    before_nxt    = before_r;
    seq_len_nxt   = seq_len_r;
    total_nxt     = total_r;
    scan_p_nxt    = scan_p_r;
    pv_nxt        = pv_r;
    pp_nxt        = pp_r;
    clr_idx_nxt   = clr_idx_r;
    clr_pend_nxt  = clr_pend_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    slot_re    = 1'b0;
    slot_raddr = '0;
    pv_we      = 1'b0;
    pv_waddr   = '0;
    pv_wdata   = '0;
    pv_re      = 1'b0;
    pv_raddr   = '0;

    // result taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // wipe the loaded flags, one value a cycle
      S_CLEAR: begin
        pv_we    = 1'b1;
        pv_waddr = clr_idx_r;
        pv_wdata = '0;
        if (clr_idx_r == LAST_IDX) begin
          clr_idx_nxt = '0;
          state_nxt   = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          before_nxt = total_r;
          op_nxt     = in_word.op;
          k_nxt      = in_k;
          status_nxt = ST_OK;
          state_nxt  = S_FINISH;
          if (in_word.op == OP_CLEAR) begin
            total_nxt    = '0;
            seq_len_nxt  = '0;
            clr_pend_nxt = 1'b1;
          end else if (in_word.op == OP_APPEND || in_word.op == OP_DELETE) begin
            if (!in_range) begin
              status_nxt = ST_RANGE;
            end else begin
              // look up the value's flag and slot
              pv_re     = 1'b1;
              pv_raddr  = in_k;
              state_nxt = S_LOOK;
            end
          end
        end
      end

      // checks in order: presence, then room
      S_LOOK: begin
        scan_p_nxt = '0;
        state_nxt  = S_SCAN;
        if (op_r == OP_APPEND) begin
          if (pv_rdata[AW]) begin
            status_nxt = ST_DUP;
            state_nxt  = S_FINISH;
          end else if (seq_len_r == LW'(MAX_ELEMS)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_FINISH;
          end
        end else begin
          if (!pv_rdata[AW]) begin
            status_nxt = ST_DUP;
            state_nxt  = S_FINISH;
          end else begin
            pos_nxt = pv_rdata[AW-1:0];
          end
        end
      end

      // one slot read a cycle, compared in the cycle after the read
      S_SCAN: begin
        if (scan_p_r < seq_len_r) begin
          slot_re    = 1'b1;
          slot_raddr = scan_p_r[AW-1:0];
          pv_nxt     = 1'b1;
          pp_nxt     = scan_p_r[AW-1:0];
          scan_p_nxt = scan_p_r + LW'(1);
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            state_nxt = S_WRITE;
          end
        end
      end

      S_WRITE: begin
        state_nxt = S_FINISH;
        pv_we     = 1'b1;
        pv_waddr  = k_r;
        slot_we   = 1'b1;
        if (op_r == OP_APPEND) begin
          slot_waddr  = seq_len_r[AW-1:0];
          slot_wdata  = {1'b1, k_r};
          pv_wdata    = {1'b1, seq_len_r[AW-1:0]};
          seq_len_nxt = seq_len_r + LW'(1);
          total_nxt   = total_r + TW'(cnt);
        end else begin
          slot_waddr = pos_r;
          slot_wdata = '0;
          pv_wdata   = '0;
          if (TW'(cnt) <= total_r) begin
            total_nxt = total_r - TW'(cnt);
          end else begin
            total_nxt = '0;
          end
        end
      end

      // wait for the output register to be free
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                  = 1'b1;
          out_word_nxt.inversions_before = CNT_W'(before_r);
          out_word_nxt.inversions_after  = CNT_W'(total_r);
          out_word_nxt.status            = status_r;
          clr_pend_nxt                   = 1'b0;
          clr_idx_nxt                    = '0;
          state_nxt                      = clr_pend_r ? S_CLEAR : S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      seq_len_r   <= '0;
      total_r     <= '0;
      pv_r        <= 1'b0;
      clr_idx_r   <= '0;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seq_len_r   <= seq_len_nxt;
      total_r     <= total_nxt;
      pv_r        <= pv_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_pend_r  <= clr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    k_r        <= k_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
    before_r   <= before_nxt;
    scan_p_r   <= scan_p_nxt;
    pp_r       <= pp_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/dic_ram.sv =====
module dic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dic_cmp_unit.sv =====
module dic_cmp_unit #(
  parameter int AW = 10,
  parameter int LW = 11
) (
  input  logic              clk,
  input  dic_pkg::cmp_ctrl_t ctrl,
  input  logic [AW:0]       slot_word,
  input  logic [AW-1:0]     p,
  input  logic [AW-1:0]     pos,
  input  logic [AW-1:0]     k,
  output logic [LW-1:0]     cnt
);
  import dic_pkg::*;

  logic          alive;
  logic [AW-1:0] val;
  logic          hit;
  logic [LW-1:0] cnt_r;
  logic [LW-1:0] cnt_nxt;

  assign alive = slot_word[AW];
  assign val   = slot_word[AW-1:0];

  // append: earlier bigger values; delete: bigger before or smaller after the slot
  always_comb begin
    if (ctrl.is_del) begin
      hit = alive && (((p < pos) && (val > k)) || ((p > pos) && (val < k)));
    end else begin
      hit = alive && (val > k);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.clear) begin
      cnt_nxt = '0;
    end else if (ctrl.valid && hit) begin
      cnt_nxt = cnt_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

  assign cnt = cnt_r;

endmodule

// ===== rtl/dic_checker.sv =====
module dic_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input dic_pkg::out_word_t out_word
);
  import dic_pkg::*;

  // count after the last delivered word
  logic [CNT_W-1:0] last_after_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_after_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_after_r <= out_word.inversions_after;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_count_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> out_word.inversions_before == last_after_r)
    else $error("count before does not follow previous count after");

  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_OK |->
      out_word.inversions_after == out_word.inversions_before)
    else $error("rejected word changed the count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in work");

endmodule

bind dynamic_inversion_counter dic_checker u_dic_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
